@@ design/svpwm_pkg.sv @@
// shared types, widths and constants for the svpwm sector duty block
package svpwm_pkg;

    localparam int DUTY_BITS       = 16;
    localparam int VOLT_W          = 16;
    localparam int BUS_W           = 15;
    localparam int GAIN_W          = 29;
    localparam int GAIN_LO_W       = 15;
    localparam int PROJ_W          = 35;
    localparam int QUEUE_DEPTH_DEF = 4;

    // sqrt3 with 28 fraction bits, and the gain for the reset bus voltage of 1000
    localparam logic [GAIN_W-1:0] SQRT3_Q28  = 29'd464943848;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 29'd464944;

    typedef logic [2:0] t_sector;

    // sign codes: bit0 a0 positive, bit1 a1 positive, bit2 a2 positive
    localparam t_sector SEC_NONE  = 3'd0;
    localparam t_sector SEC_A0    = 3'd1;
    localparam t_sector SEC_A1    = 3'd2;
    localparam t_sector SEC_A0_A1 = 3'd3;
    localparam t_sector SEC_A2    = 3'd4;
    localparam t_sector SEC_A0_A2 = 3'd5;
    localparam t_sector SEC_A1_A2 = 3'd6;
    localparam t_sector SEC_ALL   = 3'd7;

    typedef struct packed {
        logic signed [VOLT_W-1:0] volt_d;
        logic signed [VOLT_W-1:0] volt_q;
        logic signed [VOLT_W-1:0] angle_sin;
        logic signed [VOLT_W-1:0] angle_cos;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty_phase_a;
        logic [DUTY_BITS-1:0] duty_phase_b;
        logic [DUTY_BITS-1:0] duty_phase_c;
        t_sector              sector_code;
        logic                 overmodulated;
    } t_out_item;

    typedef struct packed {
        t_sector                  sector;
        logic signed [PROJ_W-1:0] p1;
        logic signed [PROJ_W-1:0] p2;
    } t_queue_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

endpackage

@@ design/svpwm_sector_duty.sv @@
// top level of the space vector pwm sector duty block
//
//  channel   handshake                    payload            direction
//  input     i_in_valid / o_in_ready      i_in_data          in  (t_in_item)
//  output    o_out_valid / i_out_ready    o_out_data         out (t_out_item)
//  config    i_cfg_valid / o_cfg_ready    i_cfg_data         in  (bus voltage)
//
// one transaction per cycle sustained while no gain update runs and the output is
// taken; the path from input acceptance to o_out_valid runs through four front
// stages, the queue write, four back stages and the output register
// a bus voltage write starts a bit-serial divide for the gain;
// o_cfg_ready and o_in_ready stay low while it runs
// synchronous active-low reset loads the gain for a bus voltage of 1000
// the front stalls only when the queue is full; the back stalls only when
// the output register holds an untaken result
module svpwm_sector_duty
    import svpwm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [BUS_W-1:0] i_cfg_data
);

    logic              w_div_busy;
    logic [GAIN_W-1:0] w_gain;
    logic              w_push;
    logic              w_pop;
    t_queue_entry      w_push_data;
    t_queue_entry      w_pop_data;
    t_queue_stat       w_queue_stat;

    // gain = round(sqrt3 / bus voltage), q28, recomputed on each config write
    svpwm_gain_div u_gain_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (w_div_busy),
        .o_gain      (w_gain)
    );

    // inverse park, projections and sector code; input held off while the gain updates
    svpwm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_hold       (w_div_busy),
        .i_queue_stat (w_queue_stat),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    // decouples the front from output backpressure
    svpwm_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_queue_entry))
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data (w_push_data),
        .i_pop     (w_pop),
        .o_rd_data (w_pop_data),
        .o_stat    (w_queue_stat)
    );

    // active times, zero vector split, phase routing and clamping
    svpwm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_queue_stat (w_queue_stat),
        .o_pop        (w_pop),
        .i_pop_data   (w_pop_data),
        .i_gain       (w_gain),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

@@ design/svpwm_gain_div.sv @@
// gain divider: sqrt3 / bus voltage, one quotient bit per cycle
module svpwm_gain_div
    import svpwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BUS_W-1:0]  i_cfg_data,
    output logic              o_busy,
    output logic [GAIN_W-1:0] o_gain
);

    localparam int CNT_W = $clog2(GAIN_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [GAIN_W-1:0] r_gain;
    logic [BUS_W-1:0]  r_div;
    logic [BUS_W-1:0]  r_rem;
    logic [GAIN_W-1:0] r_quo;

    logic              w_accept;
    logic [BUS_W-1:0]  w_div_in;
    logic [GAIN_W-1:0] w_num;
    logic [BUS_W:0]    w_trial;
    logic [BUS_W:0]    w_diff;
    logic              w_ge;
    logic [BUS_W-1:0]  w_rem_next;

    assign w_accept   = i_cfg_valid && o_cfg_ready;
    // zero bus voltage counts as one
    assign w_div_in   = (i_cfg_data == '0) ? BUS_W'(1) : i_cfg_data;
    assign w_num      = SQRT3_Q28 + GAIN_W'(w_div_in >> 1);
    assign w_trial    = {r_rem, r_quo[GAIN_W-1]};
    assign w_diff     = w_trial - {1'b0, r_div};
    assign w_ge       = (w_trial >= {1'b0, r_div});
    assign w_rem_next = w_ge ? w_diff[BUS_W-1:0] : w_trial[BUS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_gain <= GAIN_RESET;
        end else if (w_accept) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(GAIN_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_gain <= {r_quo[GAIN_W-2:0], w_ge};
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_div <= w_div_in;
            r_rem <= '0;
            r_quo <= w_num;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_quo <= {r_quo[GAIN_W-2:0], w_ge};
        end
    end

    assign o_cfg_ready = !r_busy;
    assign o_busy      = r_busy;
    assign o_gain      = r_gain;

endmodule

@@ design/svpwm_queue.sv @@
// small register queue between the classify front and the duty back
module svpwm_queue
    import svpwm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int WIDTH = $bits(t_queue_entry)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output t_queue_stat      o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_rd_data    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

@@ design/svpwm_front.sv @@
// front: inverse park, projections and sector classification
module svpwm_front
    import svpwm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  t_in_item     i_in_data,
    input  logic         i_hold,
    input  t_queue_stat  i_queue_stat,
    output logic         o_push,
    output t_queue_entry o_push_data
);

    localparam int PRD_W  = 2 * VOLT_W;
    localparam int AB_W   = PRD_W + 1;
    localparam int K_W    = 18;
    localparam int M_W    = AB_W + K_W;
    localparam int X_W    = M_W + 1;
    localparam int Q_SHFT = 15;
    localparam int STAGES = 4;

    // sqrt3/2 with 16 fraction bits
    localparam logic signed [K_W-1:0] HALF_SQRT3 = 18'sd56756;

    logic [STAGES-1:0] r_valid;

    logic signed [PRD_W-1:0]  r_vd_cs, r_vq_sn, r_vd_sn, r_vq_cs;
    logic signed [AB_W-1:0]   r_alpha, r_beta;
    logic signed [M_W-1:0]    r_m;
    logic signed [AB_W-1:0]   r_beta3;
    logic signed [PROJ_W-1:0] r_a0, r_a1, r_a2;

    logic                     w_stall;
    logic                     w_adv;
    logic                     w_accept;
    logic signed [X_W-1:0]    w_x1, w_x2;
    logic                     w_pos0, w_pos1, w_pos2;
    t_sector                  w_sector;
    logic signed [PROJ_W-1:0] w_p1, w_p2;

    assign w_stall    = r_valid[STAGES-1] && i_queue_stat.full;
    assign w_adv      = !w_stall;
    assign o_in_ready = !i_hold && !w_stall;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_x1 = X_W'(r_m) - (X_W'(r_beta3) <<< Q_SHFT);
    assign w_x2 = -X_W'(r_m) - (X_W'(r_beta3) <<< Q_SHFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_adv) begin
            r_valid <= {r_valid[STAGES-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vd_cs <= i_in_data.volt_d * i_in_data.angle_cos;
            r_vq_sn <= i_in_data.volt_q * i_in_data.angle_sin;
            r_vd_sn <= i_in_data.volt_d * i_in_data.angle_sin;
            r_vq_cs <= i_in_data.volt_q * i_in_data.angle_cos;

            r_alpha <= AB_W'(r_vd_cs) - AB_W'(r_vq_sn);
            r_beta  <= AB_W'(r_vd_sn) + AB_W'(r_vq_cs);

            r_m     <= r_alpha * HALF_SQRT3;
            r_beta3 <= r_beta;

            r_a0 <= PROJ_W'(r_beta3) <<< 1;
            r_a1 <= PROJ_W'(w_x1 >>> Q_SHFT);
            r_a2 <= PROJ_W'(w_x2 >>> Q_SHFT);
        end
    end

    // strictly positive tests
    assign w_pos0   = !r_a0[PROJ_W-1] && (r_a0 != '0);
    assign w_pos1   = !r_a1[PROJ_W-1] && (r_a1 != '0);
    assign w_pos2   = !r_a2[PROJ_W-1] && (r_a2 != '0);
    assign w_sector = {w_pos2, w_pos1, w_pos0};

    // active vector projections per sector
    always_comb begin
        unique case (w_sector)
            SEC_A0_A1: begin w_p1 = r_a1;  w_p2 = r_a0;  end
            SEC_A0:    begin w_p1 = -r_a1; w_p2 = -r_a2; end
            SEC_A0_A2: begin w_p1 = r_a0;  w_p2 = r_a2;  end
            SEC_A2:    begin w_p1 = -r_a0; w_p2 = -r_a1; end
            SEC_A1_A2: begin w_p1 = r_a2;  w_p2 = r_a1;  end
            SEC_A1:    begin w_p1 = -r_a2; w_p2 = -r_a0; end
            default:   begin w_p1 = '0;    w_p2 = '0;    end
        endcase
    end

    assign o_push             = r_valid[STAGES-1] && !i_queue_stat.full;
    assign o_push_data.sector = w_sector;
    assign o_push_data.p1     = w_p1;
    assign o_push_data.p2     = w_p2;

endmodule

@@ design/svpwm_back.sv @@
// back: gain scaling, zero vector split, phase routing and saturation
module svpwm_back
    import svpwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_queue_stat       i_queue_stat,
    output logic              o_pop,
    input  t_queue_entry      i_pop_data,
    input  logic [GAIN_W-1:0] i_gain,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data
);

    localparam int GAIN_HI_W = GAIN_W - GAIN_LO_W;
    localparam int LO_W      = PROJ_W + GAIN_LO_W + 1;
    localparam int HI_W      = PROJ_W + GAIN_HI_W + 1;
    localparam int SUM_W     = HI_W + GAIN_LO_W + 1;
    localparam int D_W       = 56;
    localparam int FRAC_W    = 32;
    localparam int T_SHIFT   = 12;
    localparam int STAGES    = 4;

    localparam logic signed [D_W-1:0] ONE_Q32  = D_W'(64'h1_0000_0000);
    localparam logic signed [D_W-1:0] HALF_Q32 = D_W'(64'h0_8000_0000);

    function automatic logic [DUTY_BITS:0] sat_duty(input logic signed [D_W-1:0] d);
        logic [DUTY_BITS:0] res;
        if (d[D_W-1]) begin
            res = {1'b1, {DUTY_BITS{1'b0}}};
        end else if (d > ONE_Q32) begin
            res = {1'b1, {DUTY_BITS{1'b1}}};
        end else if (d == ONE_Q32) begin
            res = {1'b0, {DUTY_BITS{1'b1}}};
        end else begin
            res = {1'b0, d[FRAC_W-1 -: DUTY_BITS]};
        end
        return res;
    endfunction

    logic [STAGES-1:0] r_valid;
    logic              r_out_valid;
    t_out_item         r_out;

    t_sector                 r_sec1, r_sec2, r_sec3, r_sec4;
    logic signed [LO_W-1:0]  r_p1_lo, r_p2_lo;
    logic signed [HI_W-1:0]  r_p1_hi, r_p2_hi;
    logic signed [D_W-1:0]   r_t1, r_t2, r_t1_3, r_t2_3;
    logic signed [D_W-1:0]   r_d0, r_d0_4, r_d1, r_d2;

    logic                     w_adv;
    logic signed [PROJ_W-1:0] w_p1, w_p2;
    logic signed [GAIN_LO_W:0] w_glo;
    logic signed [GAIN_HI_W:0] w_ghi;
    logic signed [SUM_W-1:0]  w_sum1, w_sum2;
    logic signed [D_W-1:0]    w_da, w_db, w_dc;
    logic [DUTY_BITS:0]       w_sa, w_sb, w_sc;

    assign w_adv = !(r_out_valid && !i_out_ready);
    assign o_pop = w_adv && !i_queue_stat.empty;

    assign w_p1  = i_pop_data.p1;
    assign w_p2  = i_pop_data.p2;
    assign w_glo = $signed({1'b0, i_gain[GAIN_LO_W-1:0]});
    assign w_ghi = $signed({1'b0, i_gain[GAIN_W-1:GAIN_LO_W]});

    assign w_sum1 = (SUM_W'(r_p1_hi) <<< GAIN_LO_W) + SUM_W'(r_p1_lo);
    assign w_sum2 = (SUM_W'(r_p2_hi) <<< GAIN_LO_W) + SUM_W'(r_p2_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid     <= {r_valid[STAGES-2:0], o_pop};
            r_out_valid <= r_valid[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // split gain multiply, low and high partial products
            r_p1_lo <= w_p1 * w_glo;
            r_p1_hi <= w_p1 * w_ghi;
            r_p2_lo <= w_p2 * w_glo;
            r_p2_hi <= w_p2 * w_ghi;
            r_sec1  <= i_pop_data.sector;

            r_t1   <= D_W'(w_sum1 >>> T_SHIFT);
            r_t2   <= D_W'(w_sum2 >>> T_SHIFT);
            r_sec2 <= r_sec1;

            r_d0   <= (ONE_Q32 - r_t1 - r_t2) >>> 1;
            r_t1_3 <= r_t1;
            r_t2_3 <= r_t2;
            r_sec3 <= r_sec2;

            r_d0_4 <= r_d0;
            r_d1   <= r_d0 + r_t2_3;
            r_d2   <= r_d0 + r_t2_3 + r_t1_3;
            r_sec4 <= r_sec3;

            r_out.duty_phase_a  <= w_sa[DUTY_BITS-1:0];
            r_out.duty_phase_b  <= w_sb[DUTY_BITS-1:0];
            r_out.duty_phase_c  <= w_sc[DUTY_BITS-1:0];
            r_out.sector_code   <= r_sec4;
            r_out.overmodulated <= w_sa[DUTY_BITS] | w_sb[DUTY_BITS] | w_sc[DUTY_BITS];
        end
    end

    always_comb begin
        unique case (r_sec4)
            SEC_A0_A1: begin w_da = r_d2;   w_db = r_d1;   w_dc = r_d0_4; end
            SEC_A0:    begin w_da = r_d1;   w_db = r_d2;   w_dc = r_d0_4; end
            SEC_A0_A2: begin w_da = r_d0_4; w_db = r_d2;   w_dc = r_d1;   end
            SEC_A2:    begin w_da = r_d0_4; w_db = r_d1;   w_dc = r_d2;   end
            SEC_A1_A2: begin w_da = r_d1;   w_db = r_d0_4; w_dc = r_d2;   end
            SEC_A1:    begin w_da = r_d2;   w_db = r_d0_4; w_dc = r_d1;   end
            default:   begin w_da = HALF_Q32; w_db = HALF_Q32; w_dc = HALF_Q32; end
        endcase
    end

    assign w_sa = sat_duty(w_da);
    assign w_sb = sat_duty(w_db);
    assign w_sc = sat_duty(w_dc);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
